FILE: hdl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types and constants for the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int CW  = 8;   // channel width
    localparam int HW  = 12;  // hue width
    localparam int QW  = 10;  // quotient bits produced by the divider
    localparam int RW  = 18;  // partial remainder width
    localparam int BPS = 2;   // quotient bits per divider stage
    localparam int DIV_STAGES = QW / BPS;

    localparam logic [9:0]    HUE_SCALE = 10'd600;
    localparam logic [CW-1:0] SAT_SCALE = 8'd255;

    localparam logic [HW-1:0] OFS_RED     = 12'd0;
    localparam logic [HW-1:0] OFS_RED_NEG = 12'd3600;
    localparam logic [HW-1:0] OFS_GREEN   = 12'd1200;
    localparam logic [HW-1:0] OFS_BLUE    = 12'd2400;

    typedef struct packed {
        logic [CW-1:0] hi;
        logic [CW-1:0] delta;
        logic [CW-1:0] diff;
        logic [HW-1:0] offset;
        logic          neg;
        logic          defined;
    } rth_sort_t;

    typedef struct packed {
        logic [RW-1:0] hue_rem;
        logic [RW-1:0] sat_rem;
        logic [CW-1:0] delta;
        logic [CW-1:0] hi;
        logic [QW-1:0] hue_q;
        logic [QW-1:0] sat_q;
        logic [HW-1:0] offset;
        logic          neg;
        logic          defined;
    } rth_div_t;

endpackage

FILE: hdl/rth_sort.sv
// ----------------------------------------------------------------------------
// rth_sort
// Stage 1: max, min, hue sector, signed channel difference.
// ----------------------------------------------------------------------------
module rth_sort
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic [rth_pkg::CW-1:0]  red,
    input  logic [rth_pkg::CW-1:0]  green,
    input  logic [rth_pkg::CW-1:0]  blue,
    output logic                    vld_reg,
    output rth_pkg::rth_sort_t      data_reg
);

    rth_pkg::rth_sort_t data_next;

    always_comb
    begin
        logic [rth_pkg::CW-1:0] hi;
        logic [rth_pkg::CW-1:0] lo;
        logic [rth_pkg::CW-1:0] a;
        logic [rth_pkg::CW-1:0] b;
        logic [rth_pkg::HW-1:0] ofs_pos;
        logic [rth_pkg::HW-1:0] ofs_neg;

        hi = (red > green) ? red : green;
        hi = (hi > blue) ? hi : blue;
        lo = (red < green) ? red : green;
        lo = (lo < blue) ? lo : blue;

        // ties: red, then green
        if (red == hi)
        begin
            a = green;
            b = blue;
            ofs_pos = rth_pkg::OFS_RED;
            ofs_neg = rth_pkg::OFS_RED_NEG;
        end
        else if (green == hi)
        begin
            a = blue;
            b = red;
            ofs_pos = rth_pkg::OFS_GREEN;
            ofs_neg = rth_pkg::OFS_GREEN;
        end
        else
        begin
            a = red;
            b = green;
            ofs_pos = rth_pkg::OFS_BLUE;
            ofs_neg = rth_pkg::OFS_BLUE;
        end

        data_next.hi      = hi;
        data_next.delta   = hi - lo;
        data_next.neg     = (a < b);
        data_next.diff    = (a < b) ? (b - a) : (a - b);
        data_next.offset  = (a < b) ? ofs_neg : ofs_pos;
        data_next.defined = (hi != lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_vld)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hdl/rth_scale.sv
// ----------------------------------------------------------------------------
// rth_scale
// Stage 2: scales the dividends, 600*diff for hue and 255*delta for saturation.
// ----------------------------------------------------------------------------
module rth_scale
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  rth_pkg::rth_sort_t  din,
    output logic                vld_reg,
    output rth_pkg::rth_div_t   data_reg
);

    rth_pkg::rth_div_t data_next;

    always_comb
    begin
        data_next.hue_rem = rth_pkg::RW'(din.diff) * rth_pkg::RW'(rth_pkg::HUE_SCALE);
        data_next.sat_rem = rth_pkg::RW'(din.delta) * rth_pkg::RW'(rth_pkg::SAT_SCALE);
        data_next.delta   = din.delta;
        data_next.hi      = din.hi;
        data_next.hue_q   = '0;
        data_next.sat_q   = '0;
        data_next.offset  = din.offset;
        data_next.neg     = din.neg;
        data_next.defined = din.defined;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_vld)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hdl/rth_div_stage.sv
// ----------------------------------------------------------------------------
// rth_div_stage
// One restoring-division stage: two quotient bits each for hue and
// saturation.
// ----------------------------------------------------------------------------
module rth_div_stage
#(
    parameter int STAGE = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  rth_pkg::rth_div_t  din,
    output logic               vld_reg,
    output rth_pkg::rth_div_t  data_reg
);

    rth_pkg::rth_div_t data_next;

    always_comb
    begin
        int                     bitpos;
        logic [rth_pkg::RW-1:0] hue_dsr;
        logic [rth_pkg::RW-1:0] sat_dsr;

        data_next = din;
        for (int j = 0; j < rth_pkg::BPS; j++)
        begin
            bitpos  = rth_pkg::QW - 1 - STAGE * rth_pkg::BPS - j;
            hue_dsr = rth_pkg::RW'(din.delta) << bitpos;
            sat_dsr = rth_pkg::RW'(din.hi) << bitpos;
            if (data_next.hue_rem >= hue_dsr)
            begin
                data_next.hue_rem       = data_next.hue_rem - hue_dsr;
                data_next.hue_q[bitpos] = 1'b1;
            end
            if (data_next.sat_rem >= sat_dsr)
            begin
                data_next.sat_rem       = data_next.sat_rem - sat_dsr;
                data_next.sat_q[bitpos] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_vld)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hdl/rth_finish.sv
// ----------------------------------------------------------------------------
// rth_finish
// Last stage: sector offset plus or minus quotient, undefined-hue cases,
// output register.
// ----------------------------------------------------------------------------
module rth_finish
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  rth_pkg::rth_div_t             din,
    output logic                          vld_reg,
    output logic [rth_pkg::HW-1:0]        hue_reg,
    output logic                          hue_defined_reg,
    output logic [rth_pkg::CW-1:0]        saturation_reg,
    output logic [rth_pkg::CW-1:0]        brightness_reg
);

    logic [rth_pkg::HW-1:0] hue_next;
    logic [rth_pkg::CW-1:0] saturation_next;

    always_comb
    begin
        logic [rth_pkg::HW-1:0] q;
        logic [rth_pkg::HW-1:0] round_up;

        q        = rth_pkg::HW'(din.hue_q);
        round_up = rth_pkg::HW'(din.hue_rem != '0);
        if (!din.defined)
        begin
            hue_next = '0;
        end
        else if (din.neg)
        begin
            // floor of a negative fraction
            hue_next = din.offset - q - round_up;
        end
        else
        begin
            hue_next = din.offset + q;
        end
        saturation_next = (din.hi == '0) ? '0 : din.sat_q[rth_pkg::CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_vld)
        begin
            hue_reg         <= hue_next;
            hue_defined_reg <= din.defined;
            saturation_reg  <= saturation_next;
            brightness_reg  <= din.hi;
        end
    end

endmodule

FILE: hdl/rgb_to_hsv.sv
// Throughput: one pixel per cycle while out_ready does not stall the pipe; the
// 8 stages (sort, scale, five 2-bit divider stages, output register) each take
// a new item when the next frees.
// Stall: out_ready low holds the pipe; empty stages still fill.
// Reset: rst_n async, clears all stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv
// Pipelined RGB to HSV conversion, hue in tenths of a degree.
// ----------------------------------------------------------------------------
module rgb_to_hsv
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rth_pkg::CW-1:0]        red,
    input  logic [rth_pkg::CW-1:0]        green,
    input  logic [rth_pkg::CW-1:0]        blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rth_pkg::HW-1:0]        hue,
    output logic                          hue_defined,
    output logic [rth_pkg::CW-1:0]        saturation,
    output logic [rth_pkg::CW-1:0]        brightness
);

    localparam int NST = rth_pkg::DIV_STAGES + 3;

    logic [NST-1:0]     vld;
    logic [NST:0]       en;
    rth_pkg::rth_sort_t sort_data;
    rth_pkg::rth_div_t  div_data [rth_pkg::DIV_STAGES+1];

    always_comb
    begin
        en[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !vld[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    rth_sort u_sort
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en[0]),
        .in_vld   (in_valid),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .vld_reg  (vld[0]),
        .data_reg (sort_data)
    );

    rth_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en[1]),
        .in_vld   (vld[0]),
        .din      (sort_data),
        .vld_reg  (vld[1]),
        .data_reg (div_data[0])
    );

    for (genvar s = 0; s < rth_pkg::DIV_STAGES; s++)
    begin : g_div
        rth_div_stage #(.STAGE(s)) u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en[s+2]),
            .in_vld   (vld[s+1]),
            .din      (div_data[s]),
            .vld_reg  (vld[s+2]),
            .data_reg (div_data[s+1])
        );
    end

    rth_finish u_finish
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en[NST-1]),
        .in_vld          (vld[NST-2]),
        .din             (div_data[rth_pkg::DIV_STAGES]),
        .vld_reg         (vld[NST-1]),
        .hue_reg         (hue),
        .hue_defined_reg (hue_defined),
        .saturation_reg  (saturation),
        .brightness_reg  (brightness)
    );

    assign out_valid = vld[NST-1];

endmodule

FILE: hdl/rth_check.sv
// ----------------------------------------------------------------------------
// rth_check
// Port-level checks for rgb_to_hsv, bound to the top level.
// ----------------------------------------------------------------------------
module rth_check
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [rth_pkg::HW-1:0]  hue,
    input logic                    hue_defined,
    input logic [rth_pkg::CW-1:0]  saturation,
    input logic [rth_pkg::CW-1:0]  brightness
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(hue) && $stable(hue_defined)
            && $stable(saturation) && $stable(brightness))
        else $error("result changed while stalled");

    a_undef_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hue_defined |-> hue == '0 && saturation == '0)
        else $error("undefined hue with nonzero hue or saturation");

    a_def_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hue_defined |-> hue < 12'd3600 && saturation != '0
            && brightness != '0)
        else $error("defined hue out of range or zero saturation");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind rgb_to_hsv rth_check u_rth_check (.*);
